// File: design/assert_macros.svh
// Assertion helpers included by the contact-force RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sdpcf_pkg.sv
package sdpcf_pkg;

    // Default number of fractional bits of the fixed-point format.
    localparam int FRAC_BITS_DEF = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_BOX_LENGTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERSE_BOX  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TILT_OFFSET  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS_SMALL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS_LARGE = 3'd4;

    // Reset value of the reciprocal box length, Q0.32 of 1/40.
    localparam logic [31:0] INVERSE_BOX_RESET = 32'd107374182;

    typedef struct packed {
        logic signed [31:0] x_first;
        logic signed [31:0] y_first;
        logic               species_first;
        logic signed [31:0] x_second;
        logic signed [31:0] y_second;
        logic               species_second;
    } in_word_t;

    typedef struct packed {
        logic               in_contact;
        logic               zero_distance;
        logic signed [31:0] sep_x;
        logic signed [31:0] sep_y;
        logic        [31:0] distance;
        logic signed [31:0] force_scalar;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
    } out_word_t;

endpackage

// File: design/soft_disk_pair_contact_force.sv
// Harmonic soft-disk pair contact force in a sheared periodic box. Each input word holds
// two disk positions and size classes; the block finds the minimum-image separation
// (vertical image count first, tilt shift of x, then wrapping of both axes with rounding
// half away from zero through the reciprocal box length), the floored distance, the
// contact flag against the summed radii, the force scalar -2(1-r/sigma)/sigma and the
// force on the first disk, all saturated to 32 bits. The block is a fully pipelined
// 62-stage datapath: it takes one word per clock cycle while the output side does not
// stall. Most of its depth lies in the three digit-recurrence units, each 16 stages
// deep at two result bits per stage: the integer square root of the 64-bit squared
// distance, the division of the force numerator by sigma squared, and the two component
// divisions by the distance. Every stage carries its own valid bit and holds only while
// all stages after it are full and the output word is not taken, so bubbles close up
// and a waiting result blocks new input words only once every stage is full.
// Configuration writes take effect at once and are meant to be made while no word is
// in flight; the block needs no start-up pass after reset.
`include "assert_macros.svh"

module soft_disk_pair_contact_force #(
    parameter int FRAC_BITS = sdpcf_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  sdpcf_pkg::in_word_t                  in_word,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output sdpcf_pkg::out_word_t                 out_word,
    input  logic                                 cfg_write,
    input  logic [sdpcf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sdpcf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Stage map.
    localparam int ST_SQ0 = 10;                    // square root setup
    localparam int SQ_PER = 2;                     // result bits per stage
    localparam int SQ_ST  = 32 / SQ_PER;
    localparam int ST_FD0 = ST_SQ0 + SQ_ST + 1;    // force division setup
    localparam int FD_ST  = 32 / SQ_PER;
    localparam int ST_CD0 = ST_FD0 + FD_ST + 1;    // component division setup
    localparam int CD_ST  = 32 / SQ_PER;
    localparam int ST_OUT = ST_CD0 + CD_ST + 1;
    localparam int NST    = ST_OUT + 1;

    // Force numerator (sigma - r) << (2F+1) and its part above bit 31.
    localparam int SHIFT_W = 2 * FRAC_BITS + 1;
    localparam int NUM_W   = 22 + SHIFT_W;
    localparam int HI_W    = NUM_W - 32;

    localparam logic [30:0] BOX_RESET   = 31'(64'd40 << FRAC_BITS);
    localparam logic [20:0] SMALL_RESET = 21'(64'd1 << (FRAC_BITS - 1));
    localparam logic [20:0] LARGE_RESET = 21'((64'd7 << FRAC_BITS) / 10);

    localparam logic [33:0] K_MAX34 = 34'h0_8000_0000;
    localparam logic [63:0] K_MAX64 = 64'h0000_0000_8000_0000;

    typedef struct packed {
        logic               contact;
        logic               zero;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic        [21:0] sg;
        logic        [43:0] sgsq;
        logic        [31:0] r;
        logic        [31:0] fmag;
    } side_t;

    typedef struct packed {
        logic [35:0] rem;
        logic [31:0] root;
        logic [63:0] src;
    } sq_t;

    typedef struct packed {
        logic [43:0] rem;
        logic [31:0] num;
        logic [31:0] quo;
        logic        sat;
    } fd_t;

    typedef struct packed {
        logic [31:0] rem_x;
        logic [31:0] num_x;
        logic [31:0] quo_x;
        logic [31:0] rem_y;
        logic [31:0] num_y;
        logic [31:0] quo_y;
    } cd_t;

    function automatic logic signed [31:0] sat32(logic signed [64:0] v);
        logic signed [31:0] res;
        if (v > 65'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end
        else if (v < -65'sd2147483648) begin
            res = 32'sh8000_0000;
        end
        else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic sq_t sq_pass(sq_t a);
        sq_t         b;
        logic [35:0] cur;
        logic [35:0] trial;
        b = a;
        for (int j = 0; j < SQ_PER; j++) begin
            cur   = {b.rem[33:0], b.src[63:62]};
            trial = {2'b00, b.root, 2'b01};
            if (cur >= trial) begin
                b.rem  = cur - trial;
                b.root = {b.root[30:0], 1'b1};
            end
            else begin
                b.rem  = cur;
                b.root = {b.root[30:0], 1'b0};
            end
            b.src = {b.src[61:0], 2'b00};
        end
        return b;
    endfunction

    function automatic fd_t fd_pass(fd_t a, logic [43:0] d);
        fd_t         b;
        logic [44:0] cur;
        logic [44:0] diff;
        b = a;
        for (int j = 0; j < SQ_PER; j++) begin
            cur  = {b.rem, b.num[31]};
            diff = cur - {1'b0, d};
            if (cur >= {1'b0, d}) begin
                b.rem = diff[43:0];
                b.quo = {b.quo[30:0], 1'b1};
            end
            else begin
                b.rem = cur[43:0];
                b.quo = {b.quo[30:0], 1'b0};
            end
            b.num = {b.num[30:0], 1'b0};
        end
        return b;
    endfunction

    // One restoring division step: returns {new remainder, quotient bit}.
    function automatic logic [32:0] div_step(logic [31:0] rem, logic nbit, logic [31:0] d);
        logic [32:0] cur;
        logic [32:0] diff;
        logic [32:0] res;
        cur  = {rem, nbit};
        diff = cur - {1'b0, d};
        if (cur >= {1'b0, d}) begin
            res = {diff[31:0], 1'b1};
        end
        else begin
            res = {cur[31:0], 1'b0};
        end
        return res;
    endfunction

    function automatic cd_t cd_pass(cd_t a, logic [31:0] d);
        cd_t         b;
        logic [32:0] sx;
        logic [32:0] sy;
        b = a;
        for (int j = 0; j < SQ_PER; j++) begin
            sx      = div_step(b.rem_x, b.num_x[31], d);
            sy      = div_step(b.rem_y, b.num_y[31], d);
            b.rem_x = sx[32:1];
            b.quo_x = {b.quo_x[30:0], sx[0]};
            b.num_x = {b.num_x[30:0], 1'b0};
            b.rem_y = sy[32:1];
            b.quo_y = {b.quo_y[30:0], sy[0]};
            b.num_y = {b.num_y[30:0], 1'b0};
        end
        return b;
    endfunction

    // Force component: the magnitude takes the sign opposite to the separation.
    function automatic logic [31:0] comp_sign(logic [31:0] q, logic sep_neg);
        logic [31:0] res;
        if (sep_neg) begin
            res = q[31] ? 32'h7FFF_FFFF : q;
        end
        else begin
            res = ~q + 32'd1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic        [30:0] box_length_reg;
    logic        [31:0] inverse_box_reg;
    logic signed [31:0] tilt_offset_reg;
    logic        [20:0] radius_small_reg;
    logic        [20:0] radius_large_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            box_length_reg   <= BOX_RESET;
            inverse_box_reg  <= sdpcf_pkg::INVERSE_BOX_RESET;
            tilt_offset_reg  <= '0;
            radius_small_reg <= SMALL_RESET;
            radius_large_reg <= LARGE_RESET;
        end
        else if (cfg_write) begin
            unique case (cfg_index)
                sdpcf_pkg::CFG_BOX_LENGTH:   box_length_reg   <= cfg_data[30:0];
                sdpcf_pkg::CFG_INVERSE_BOX:  inverse_box_reg  <= cfg_data;
                sdpcf_pkg::CFG_TILT_OFFSET:  tilt_offset_reg  <= cfg_data;
                sdpcf_pkg::CFG_RADIUS_SMALL: radius_small_reg <= cfg_data[20:0];
                sdpcf_pkg::CFG_RADIUS_LARGE: radius_large_reg <= cfg_data[20:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and advance enables. A stage may load when it or
    // any stage after it is empty, or whenever the output moves.
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] adv;
    logic [NST-1:0] vld_in;

    always_comb begin
        logic [NST-1:0] lowmask;
        for (int i = 0; i < NST; i++) begin
            lowmask = (NST'(1) << i) - NST'(1);
            adv[i]  = out_ready || !(&(vld_reg | lowmask));
        end
    end

    assign vld_in = {vld_reg[NST-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            for (int i = 0; i < NST; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NST-1];

    // ------------------------------------------------------------------
    // Front section: differences, image counts and wrapping.
    // ------------------------------------------------------------------
    logic signed [32:0] dx0_reg, dx1_reg, dx2_reg, dx3_reg;
    logic signed [32:0] dy0_reg, dy1_reg, dy2_reg, dy3_reg;
    logic        [21:0] sg0_reg, sg1_reg, sg2_reg, sg3_reg, sg4_reg;
    logic        [21:0] sg5_reg, sg6_reg, sg7_reg, sg8_reg, sg9_reg;
    logic        [43:0] sgsq1_reg, sgsq2_reg, sgsq3_reg, sgsq4_reg;
    logic        [43:0] sgsq5_reg, sgsq6_reg, sgsq7_reg, sgsq8_reg, sgsq9_reg;
    logic        [64:0] prody1_reg;
    logic               negy1_reg;
    logic signed [32:0] ky2_reg;
    logic signed [63:0] tprod3_reg;
    logic signed [63:0] ly3_reg;
    logic signed [63:0] dxs4_reg, dxs5_reg, dxs6_reg, dxs7_reg;
    logic signed [31:0] sy4_reg, sy5_reg, sy6_reg, sy7_reg, sy8_reg, sy9_reg;
    logic        [63:0] lo5_reg;
    logic        [62:0] hi5_reg;
    logic               negx5_reg;
    logic signed [32:0] kx6_reg;
    logic signed [63:0] lx7_reg;
    logic signed [31:0] sx8_reg, sx9_reg;
    logic signed [63:0] sqx9_reg, sqy9_reg;

    logic        [20:0] ra;
    logic        [20:0] rb;
    logic        [32:0] magy;
    logic        [33:0] kr2;
    logic        [31:0] kc2;
    logic signed [64:0] sy_wide;
    logic        [63:0] magx;
    logic        [63:0] t6;
    logic        [63:0] kr6;
    logic        [31:0] kc6;
    logic signed [64:0] sx_wide;
    logic        [63:0] sum10;

    always_comb begin
        ra      = in_word.species_first  ? radius_large_reg : radius_small_reg;
        rb      = in_word.species_second ? radius_large_reg : radius_small_reg;
        magy    = dy0_reg[32] ? (~dy0_reg + 33'd1) : dy0_reg;
        // Image count rounded half away from zero, clamped to 2^31.
        kr2     = (({1'b0, prody1_reg[64:32]} >> (FRAC_BITS - 1)) + 34'd1) >> 1;
        kc2     = (kr2 > K_MAX34) ? K_MAX34[31:0] : kr2[31:0];
        sy_wide = dy3_reg - ly3_reg;
        magx    = dxs4_reg[63] ? (~dxs4_reg + 64'd1) : dxs4_reg;
        t6      = {1'b0, hi5_reg} + {32'd0, lo5_reg[63:32]};
        kr6     = ((t6 >> (FRAC_BITS - 1)) + 64'd1) >> 1;
        kc6     = (kr6 > K_MAX64) ? K_MAX64[31:0] : kr6[31:0];
        sx_wide = dxs7_reg - lx7_reg;
        sum10   = sqx9_reg + sqy9_reg;
    end

    sq_t   sq_reg  [SQ_ST+1];
    side_t sqs_reg [SQ_ST+1];

    always_ff @(posedge clk) begin
        if (adv[0]) begin
            dx0_reg <= $signed({in_word.x_first[31], in_word.x_first})
                     - $signed({in_word.x_second[31], in_word.x_second});
            dy0_reg <= $signed({in_word.y_first[31], in_word.y_first})
                     - $signed({in_word.y_second[31], in_word.y_second});
            sg0_reg <= {1'b0, ra} + {1'b0, rb};
        end
        if (adv[1]) begin
            prody1_reg <= {32'd0, magy} * {33'd0, inverse_box_reg};
            negy1_reg  <= dy0_reg[32];
            dx1_reg    <= dx0_reg;
            dy1_reg    <= dy0_reg;
            sg1_reg    <= sg0_reg;
            sgsq1_reg  <= {22'd0, sg0_reg} * {22'd0, sg0_reg};
        end
        if (adv[2]) begin
            ky2_reg   <= negy1_reg ? -$signed({1'b0, kc2}) : $signed({1'b0, kc2});
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            sg2_reg   <= sg1_reg;
            sgsq2_reg <= sgsq1_reg;
        end
        if (adv[3]) begin
            tprod3_reg <= tilt_offset_reg * ky2_reg;
            ly3_reg    <= $signed({1'b0, box_length_reg}) * ky2_reg;
            dx3_reg    <= dx2_reg;
            dy3_reg    <= dy2_reg;
            sg3_reg    <= sg2_reg;
            sgsq3_reg  <= sgsq2_reg;
        end
        if (adv[4]) begin
            dxs4_reg  <= dx3_reg - tprod3_reg;
            sy4_reg   <= sat32(sy_wide);
            sg4_reg   <= sg3_reg;
            sgsq4_reg <= sgsq3_reg;
        end
        if (adv[5]) begin
            lo5_reg   <= {32'd0, magx[31:0]} * {32'd0, inverse_box_reg};
            hi5_reg   <= {32'd0, magx[62:32]} * {31'd0, inverse_box_reg};
            negx5_reg <= dxs4_reg[63];
            dxs5_reg  <= dxs4_reg;
            sy5_reg   <= sy4_reg;
            sg5_reg   <= sg4_reg;
            sgsq5_reg <= sgsq4_reg;
        end
        if (adv[6]) begin
            kx6_reg   <= negx5_reg ? -$signed({1'b0, kc6}) : $signed({1'b0, kc6});
            dxs6_reg  <= dxs5_reg;
            sy6_reg   <= sy5_reg;
            sg6_reg   <= sg5_reg;
            sgsq6_reg <= sgsq5_reg;
        end
        if (adv[7]) begin
            lx7_reg   <= $signed({1'b0, box_length_reg}) * kx6_reg;
            dxs7_reg  <= dxs6_reg;
            sy7_reg   <= sy6_reg;
            sg7_reg   <= sg6_reg;
            sgsq7_reg <= sgsq6_reg;
        end
        if (adv[8]) begin
            sx8_reg   <= sat32(sx_wide);
            sy8_reg   <= sy7_reg;
            sg8_reg   <= sg7_reg;
            sgsq8_reg <= sgsq7_reg;
        end
        if (adv[9]) begin
            sqx9_reg  <= sx8_reg * sx8_reg;
            sqy9_reg  <= sy8_reg * sy8_reg;
            sx9_reg   <= sx8_reg;
            sy9_reg   <= sy8_reg;
            sg9_reg   <= sg8_reg;
            sgsq9_reg <= sgsq8_reg;
        end
        if (adv[ST_SQ0]) begin
            sq_reg[0]          <= '{rem: '0, root: '0, src: sum10};
            sqs_reg[0].contact <= sum10 < {20'd0, sgsq9_reg};
            sqs_reg[0].zero    <= (sx9_reg == 32'sd0) && (sy9_reg == 32'sd0);
            sqs_reg[0].sx      <= sx9_reg;
            sqs_reg[0].sy      <= sy9_reg;
            sqs_reg[0].sg      <= sg9_reg;
            sqs_reg[0].sgsq    <= sgsq9_reg;
            sqs_reg[0].r       <= '0;
            sqs_reg[0].fmag    <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Integer square root of the squared distance, two bits per stage.
    // ------------------------------------------------------------------
    for (genvar k = 1; k <= SQ_ST; k++) begin : g_sq
        always_ff @(posedge clk) begin
            if (adv[ST_SQ0 + k]) begin
                sq_reg[k]  <= sq_pass(sq_reg[k-1]);
                sqs_reg[k] <= sqs_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Force magnitude: floor(((sigma - r) << (2F+1)) / sigma^2), saturated
    // at 2^31. The part of the numerator above bit 31 decides saturation
    // at once and seeds the remainder; the low 32 bits are shifted in.
    // ------------------------------------------------------------------
    logic [21:0]      fdiff;
    logic [NUM_W-1:0] fnum;
    logic [HI_W-1:0]  fhi;
    side_t            fd_side;

    always_comb begin
        fdiff     = sqs_reg[SQ_ST].sg - sq_reg[SQ_ST].root[21:0];
        fnum      = {fdiff, {SHIFT_W{1'b0}}};
        fhi       = fnum[NUM_W-1:32];
        fd_side   = sqs_reg[SQ_ST];
        fd_side.r = sq_reg[SQ_ST].root;
    end

    fd_t   fd_reg  [FD_ST+1];
    side_t fds_reg [FD_ST+1];

    always_ff @(posedge clk) begin
        if (adv[ST_FD0]) begin
            fd_reg[0].rem <= 44'(fhi);
            fd_reg[0].num <= fnum[31:0];
            fd_reg[0].quo <= '0;
            fd_reg[0].sat <= 44'(fhi) >= sqs_reg[SQ_ST].sgsq;
            fds_reg[0]    <= fd_side;
        end
    end

    for (genvar k = 1; k <= FD_ST; k++) begin : g_fd
        always_ff @(posedge clk) begin
            if (adv[ST_FD0 + k]) begin
                fd_reg[k]  <= fd_pass(fd_reg[k-1], fds_reg[k-1].sgsq);
                fds_reg[k] <= fds_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Components: |F| * |sep| / r, truncated. Since |sep| <= r the
    // quotient never exceeds |F|, so 32 quotient bits suffice.
    // ------------------------------------------------------------------
    logic [31:0] fmag;
    logic [31:0] smag_x;
    logic [31:0] smag_y;
    logic [63:0] prod_x;
    logic [63:0] prod_y;
    side_t       cd_side;

    always_comb begin
        fmag   = (fd_reg[FD_ST].sat || fd_reg[FD_ST].quo[31])
               ? 32'h8000_0000 : fd_reg[FD_ST].quo;
        smag_x = fds_reg[FD_ST].sx[31] ? (~fds_reg[FD_ST].sx + 32'd1) : fds_reg[FD_ST].sx;
        smag_y = fds_reg[FD_ST].sy[31] ? (~fds_reg[FD_ST].sy + 32'd1) : fds_reg[FD_ST].sy;
        prod_x = {32'd0, fmag} * {32'd0, smag_x};
        prod_y = {32'd0, fmag} * {32'd0, smag_y};
        cd_side      = fds_reg[FD_ST];
        cd_side.fmag = fmag;
    end

    cd_t   cd_reg  [CD_ST+1];
    side_t cds_reg [CD_ST+1];

    always_ff @(posedge clk) begin
        if (adv[ST_CD0]) begin
            cd_reg[0]  <= '{rem_x: prod_x[63:32], num_x: prod_x[31:0], quo_x: '0,
                            rem_y: prod_y[63:32], num_y: prod_y[31:0], quo_y: '0};
            cds_reg[0] <= cd_side;
        end
    end

    for (genvar k = 1; k <= CD_ST; k++) begin : g_cd
        always_ff @(posedge clk) begin
            if (adv[ST_CD0 + k]) begin
                cd_reg[k]  <= cd_pass(cd_reg[k-1], cds_reg[k-1].r);
                cds_reg[k] <= cds_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output word.
    // ------------------------------------------------------------------
    sdpcf_pkg::out_word_t out_reg;
    side_t                fin;
    logic                 push_force;

    always_comb begin
        fin        = cds_reg[CD_ST];
        push_force = fin.contact && !fin.zero;
    end

    always_ff @(posedge clk) begin
        if (adv[ST_OUT]) begin
            out_reg.in_contact    <= fin.contact;
            out_reg.zero_distance <= fin.zero;
            out_reg.sep_x         <= fin.sx;
            out_reg.sep_y         <= fin.sy;
            out_reg.distance      <= fin.r;
            out_reg.force_scalar  <= fin.contact ? (~fin.fmag + 32'd1) : 32'd0;
            out_reg.force_x       <= push_force
                                   ? comp_sign(cd_reg[CD_ST].quo_x, fin.sx[31]) : 32'd0;
            out_reg.force_y       <= push_force
                                   ? comp_sign(cd_reg[CD_ST].quo_y, fin.sy[31]) : 32'd0;
        end
    end

    assign out_word = out_reg;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_no_force_without_contact,
        out_valid && !out_word.in_contact,
        out_word.force_scalar == 32'sd0 && out_word.force_x == 32'sd0
            && out_word.force_y == 32'sd0,
        "force reported without contact")

    `ASSERT_IMPL(a_zero_distance_no_components,
        out_valid && out_word.zero_distance,
        out_word.distance == 32'd0 && out_word.force_x == 32'sd0
            && out_word.force_y == 32'sd0,
        "zero separation gave nonzero distance or force components")

    `ASSERT_IMPL(a_stall_only_when_full,
        !in_ready,
        (&vld_reg) && !out_ready,
        "input stalled while the pipeline had room")

    `ASSERT_NEXT(a_accept_enters_pipe,
        in_valid && in_ready,
        vld_reg[0],
        "accepted word did not enter the first stage")

endmodule

// File: verif/soft_disk_pair_contact_force_checker.sv
`timescale 1ns / 100ps

module soft_disk_pair_contact_force_checker
    import sdpcf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  in_word_t               in_word,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  out_word_t              out_word,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     pending,
    output int                     mismatches
);

    localparam int FB = FRAC_BITS_DEF;

    // Shadow copy of the register file.
    longint unsigned box_len;
    longint unsigned inv_box;
    longint          tilt;
    longint unsigned rad_small;
    longint unsigned rad_large;

    out_word_t contact_queue[$];

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Nearest whole number of box lengths, half away from zero, clamped to 2^31.
    function automatic longint images(longint v);
        logic neg;
        longint unsigned mag, lo, hi, t, k;
        neg = v < 0;
        mag = neg ? -v : v;
        lo = (mag & 64'hFFFF_FFFF) * inv_box;
        hi = (mag >> 32) * inv_box;
        t = hi + (lo >> 32);
        k = ((t >> (FB - 1)) + 1) >> 1;
        if (k > 64'd2147483648)
            k = 64'd2147483648;
        return neg ? -longint'(k) : longint'(k);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint push_part(longint unsigned fmag, longint s, longint unsigned r);
        longint unsigned smag;
        longint q;
        smag = s < 0 ? -s : s;
        q = longint'((fmag * smag) / r);
        return clamp32(s < 0 ? q : -q);
    endfunction

    function automatic out_word_t contact_force(in_word_t w);
        out_word_t o;
        longint dx, dy, ky, kx, sx, sy, fsc, fx, fy;
        longint unsigned ra, rb, sigma, sum, r, u, q, rem, wq, fmag;
        logic touch, zero;
        dx = longint'(w.x_first) - longint'(w.x_second);
        dy = longint'(w.y_first) - longint'(w.y_second);
        ra = w.species_first ? rad_large : rad_small;
        rb = w.species_second ? rad_large : rad_small;
        sigma = ra + rb;
        fsc = 0;
        fx = 0;
        fy = 0;
        // The vertical image count also decides the shear shift of x.
        ky = images(dy);
        dx = dx - tilt * ky;
        kx = images(dx);
        sx = clamp32(dx - longint'(box_len) * kx);
        sy = clamp32(dy - longint'(box_len) * ky);
        sum = longint'(sx * sx) + longint'(sy * sy);
        r = root_floor(sum);
        touch = sum < sigma * sigma;
        zero = (sx == 0) && (sy == 0);
        if (touch)
        begin
            u = (sigma - r) << (FB + 1);
            q = u / sigma;
            rem = u % sigma;
            wq = (q << FB) + ((rem << FB) / sigma);
            fmag = wq / sigma;
            if (fmag > 64'd2147483648)
                fmag = 64'd2147483648;
            fsc = -longint'(fmag);
            if (!zero)
            begin
                fx = push_part(fmag, sx, r);
                fy = push_part(fmag, sy, r);
            end
        end
        o.in_contact = touch;
        o.zero_distance = zero;
        o.sep_x = sx[31:0];
        o.sep_y = sy[31:0];
        o.distance = r[31:0];
        o.force_scalar = fsc[31:0];
        o.force_x = fx[31:0];
        o.force_y = fy[31:0];
        return o;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic compare_word(out_word_t got, out_word_t want);
        if (got.in_contact !== want.in_contact)
            report("in_contact", got.in_contact, want.in_contact);
        if (got.zero_distance !== want.zero_distance)
            report("zero_distance", got.zero_distance, want.zero_distance);
        if (got.sep_x !== want.sep_x)
            report("sep_x", got.sep_x, want.sep_x);
        if (got.sep_y !== want.sep_y)
            report("sep_y", got.sep_y, want.sep_y);
        if (got.distance !== want.distance)
            report("distance", got.distance, want.distance);
        if (got.force_scalar !== want.force_scalar)
            report("force_scalar", got.force_scalar, want.force_scalar);
        if (got.force_x !== want.force_x)
            report("force_x", got.force_x, want.force_x);
        if (got.force_y !== want.force_y)
            report("force_y", got.force_y, want.force_y);
    endtask

    initial
    begin
        mismatches = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_len   <= 64'd40 << FB;
            inv_box   <= 64'(INVERSE_BOX_RESET);
            tilt      <= 0;
            rad_small <= 64'd1 << (FB - 1);
            rad_large <= (64'd7 << FB) / 10;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_BOX_LENGTH:   box_len   <= 64'(cfg_data[30:0]);
                    CFG_INVERSE_BOX:  inv_box   <= 64'(cfg_data);
                    CFG_TILT_OFFSET:  tilt      <= longint'(signed'(cfg_data));
                    CFG_RADIUS_SMALL: rad_small <= 64'(cfg_data[20:0]);
                    CFG_RADIUS_LARGE: rad_large <= 64'(cfg_data[20:0]);
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                contact_queue.push_back(contact_force(in_word));
            if (out_valid && out_ready)
            begin
                if (contact_queue.size() == 0)
                begin
                    $display("%0t: result word with nothing expected", $realtime);
                    mismatches++;
                end
                else
                    compare_word(out_word, contact_queue.pop_front());
            end
        end
        pending = contact_queue.size();
    end

endmodule

// File: verif/soft_disk_pair_contact_force_tb.sv
`timescale 1ns / 100ps

module soft_disk_pair_contact_force_tb;
    import sdpcf_pkg::*;

    // The pipeline is 62 stages deep; drain() keeps waiting after the last result as a margin.
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_PER_PHASE = 460;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_word_t               in_word;
    logic                   out_valid;
    logic                   out_ready;
    out_word_t              out_word;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     pending;
    int                     mismatches;

    // Idle pattern: 0 means sender 13% and receiver 59%, 1 the other way round, 2 no idling.
    int  idle_mode;
    int  words_sent;
    bit  backlog_done;

    // Copy of the settings the stimulus aims its near pairs at.
    int  cur_box;
    int  cur_sigma;

    soft_disk_pair_contact_force u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    soft_disk_pair_contact_force_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .mismatches (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    // Hard stop in case the handshake locks up.
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // The receiver. Once the sender is a couple of hundred words in, it holds off for
    // a long stretch so the pipeline fills and the block has to stall its input.
    initial
    begin
        int hold;
        out_ready = 1'b0;
        backlog_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!backlog_done && words_sent >= 200)
            begin
                backlog_done = 1'b1;
                out_ready <= 1'b0;
                for (hold = 0; hold < 300; hold++)
                    @(posedge clk);
            end
            case (idle_mode)
                0:       out_ready <= ($urandom_range(99) >= 59);
                1:       out_ready <= ($urandom_range(99) >= 13);
                default: out_ready <= 1'b1;
            endcase
        end
    end

    // Offers one word and keeps it steady until it is taken. Random gaps come first
    // so they land between words, never inside one.
    task automatic send_word(in_word_t w);
        int gap_pct;
        gap_pct = (idle_mode == 0) ? 13 : (idle_mode == 1) ? 59 : 0;
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        idle_mode = (words_sent < 640) ? 0 : (words_sent < 1280) ? 1 : 2;
    endtask

    // Lets the pipeline empty out completely before anything about it changes.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes all five registers on consecutive cycles while the block is empty.
    task automatic load_settings(int unsigned box, int unsigned inv, int tlt,
                                 int unsigned rs, int unsigned rl);
        logic [31:0] vals [5];
        int i;
        vals[0] = box;
        vals[1] = inv;
        vals[2] = tlt;
        vals[3] = rs;
        vals[4] = rl;
        drain();
        for (i = 0; i < 5; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_INDEX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        cur_box   = box[30:0];
        cur_sigma = rs[20:0] + rl[20:0];
    endtask

    function automatic in_word_t pair_at(int x1, int y1, bit s1, int x2, int y2, bit s2);
        in_word_t w;
        w.x_first        = x1;
        w.y_first        = y1;
        w.species_first  = s1;
        w.x_second       = x2;
        w.y_second       = y2;
        w.species_second = s2;
        return w;
    endfunction

    // Corner cases: coincident disks, the contact boundary, half a box, the coordinate extremes.
    task automatic directed_pairs();
        int s;
        s = cur_sigma;
        send_word(pair_at(0, 0, 0, 0, 0, 0));
        send_word(pair_at(123456, -98765, 1, 123456, -98765, 1));
        send_word(pair_at(s, 0, 0, 0, 0, 1));
        send_word(pair_at(s - 1, 0, 1, 0, 0, 0));
        send_word(pair_at(0, s - 1, 1, 0, 0, 1));
        send_word(pair_at(1, 1, 0, 0, 0, 0));
        send_word(pair_at(cur_box / 2, 0, 0, 0, 0, 0));
        send_word(pair_at(0, cur_box / 2, 1, 0, 0, 1));
        send_word(pair_at(cur_box + 100, -cur_box + 50, 0, 0, 0, 1));
        send_word(pair_at(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1,
                          32'sh8000_0000, 32'sh8000_0000, 0));
        send_word(pair_at(32'sh8000_0000, 32'sh7FFF_FFFF, 0,
                          32'sh7FFF_FFFF, 32'sh8000_0000, 1));
        send_word(pair_at(-1, -1, 1, 0, 0, 1));
    endtask

    function automatic int near_offset(int span);
        return int'($urandom_range(4 * span + 2)) - 2 * span - 1;
    endfunction

    // Mostly near pairs, each axis offset by at most 2*sigma+1 plus up to one box image; the rest fully random.
    task automatic random_pairs(int count);
        int n, x1, y1, kx, ky;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 65)
            begin
                x1 = $urandom;
                y1 = $urandom;
                kx = int'($urandom_range(2)) - 1;
                ky = int'($urandom_range(2)) - 1;
                send_word(pair_at(x1, y1, 1'($urandom_range(1)),
                                  x1 + near_offset(cur_sigma) + kx * cur_box,
                                  y1 + near_offset(cur_sigma) + ky * cur_box,
                                  1'($urandom_range(1))));
            end
            else
                send_word(pair_at($urandom, $urandom, 1'($urandom_range(1)),
                                  $urandom, $urandom, 1'($urandom_range(1))));
        end
    endtask

    initial
    begin
        int unsigned box;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_word    = '0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        idle_mode  = 0;
        words_sent = 0;
        cur_box    = 40 << 16;
        cur_sigma  = 32768 + 45875;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings first, then each phase rewrites every register.
        directed_pairs();
        random_pairs(RANDOM_PER_PHASE / 2);

        load_settings(40 << 16, 107374182, 0, 32768, 45875);
        random_pairs(RANDOM_PER_PHASE / 2);

        // A small sheared box with a tilt of three units.
        load_settings(10 << 16, 429496730, 3 << 16, 40000, 70000);
        directed_pairs();
        random_pairs(RANDOM_PER_PHASE);

        // Box length and reciprocal at their top, the tilt at its bottom, both radii at 2^20.
        load_settings(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'sh8000_0000, 1048576, 1048576);
        directed_pairs();
        random_pairs(RANDOM_PER_PHASE / 2);

        // No wrapping, and zero radii that can never touch.
        load_settings(1, 0, 32'sh7FFF_FFFF, 0, 0);
        directed_pairs();
        random_pairs(RANDOM_PER_PHASE / 4);

        // Smallest box and one radius of zero.
        load_settings(1, 1, -1, 0, 1);
        directed_pairs();
        random_pairs(RANDOM_PER_PHASE / 4);

        // Random matched boxes with random shear.
        repeat (2)
        begin
            box = $urandom_range(32'h4000_0000, 32'h0002_0000);
            load_settings(box, 32'(64'h1_0000_0000_0000 / box), $urandom,
                          $urandom_range(1048576, 1), $urandom_range(1048576, 1));
            random_pairs(RANDOM_PER_PHASE / 2);
        end

        drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/sdpcf_pkg.sv
design/soft_disk_pair_contact_force.sv
verif/soft_disk_pair_contact_force_checker.sv
verif/soft_disk_pair_contact_force_tb.sv
